// ===== hw/rtl/fftb_pkg.sv =====
// ----------------------------------------------------------------------------
// fftb_pkg
// Shared types, widths and helpers for the radix-2 butterfly stage.
// ----------------------------------------------------------------------------
package fftb_pkg;

	localparam int MAX_FFT_LOG2  = 10;
	localparam int DATA_WIDTH    = 24;
	localparam int TWIDDLE_WIDTH = 16;

	localparam int FRAC_BITS   = TWIDDLE_WIDTH - 1;
	localparam int TABLE_AW    = MAX_FFT_LOG2 - 1;
	localparam int TABLE_DEPTH = 1 << TABLE_AW;
	localparam int ENTRY_W     = 2 * TWIDDLE_WIDTH;

	// fixed field widths
	localparam int IDX_W   = 10;
	localparam int LOG_W   = 4;
	localparam int RANK_W  = 10;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 10;
	localparam int BASE_W  = RANK_W + (1 << LOG_W) - 1;

	// datapath widths
	localparam int PROD_W = TWIDDLE_WIDTH + 1 + DATA_WIDTH;
	localparam int T_W    = PROD_W + 1;
	localparam int SA_W   = DATA_WIDTH + FRAC_BITS;
	localparam int SUM_W  = T_W + 1;
	localparam int SH_W   = SUM_W - FRAC_BITS;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_BFLY = 1'b1;

	typedef enum logic [CFG_AW-1:0] {
		CFG_FFT_SIZE_LOG2  = 3'd0,
		CFG_SPAN_LOG2      = 3'd1,
		CFG_PART_SIZE_LOG2 = 3'd2,
		CFG_PART_RANK      = 3'd3,
		CFG_CONJ_TWIDDLE   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LOG_W-1:0]  fft_size_log2;
		logic [LOG_W-1:0]  span_log2;
		logic [LOG_W-1:0]  part_size_log2;
		logic [RANK_W-1:0] part_rank;
		logic              conjugate_twiddle;
	} cfg_t;

	typedef struct packed {
		logic [TABLE_AW-1:0] tidx;
		logic [IDX_W-1:0]    idx0;
		logic [IDX_W-1:0]    idx1;
		logic                is_local;
		logic                take_sum;
	} idx_t;

	// floor shift by FRAC_BITS (rounding offset already added), then saturate
	function automatic logic signed [DATA_WIDTH-1:0] round_sat(input logic signed [SUM_W-1:0] x);
		logic signed [SH_W-1:0] sh;
		logic signed [SH_W-1:0] hi;
		logic signed [SH_W-1:0] lo;
		sh = SH_W'(x >>> FRAC_BITS);
		hi = SH_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
		lo = -hi - SH_W'(1);
		if (sh > hi) begin
			round_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else if (sh < lo) begin
			round_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			round_sat = sh[DATA_WIDTH-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/fftb_if.sv =====
// ----------------------------------------------------------------------------
// fftb channel interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fftb_req_if import fftb_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [IDX_W-1:0]             element_index;
	logic signed [DATA_WIDTH-1:0] value_a_re;
	logic signed [DATA_WIDTH-1:0] value_a_im;
	logic signed [DATA_WIDTH-1:0] value_b_re;
	logic signed [DATA_WIDTH-1:0] value_b_im;
	logic signed [TWIDDLE_WIDTH-1:0] twiddle_re;
	logic signed [TWIDDLE_WIDTH-1:0] twiddle_im;

	modport source (output valid, command, element_index, value_a_re, value_a_im,
		value_b_re, value_b_im, twiddle_re, twiddle_im, input ready);
	modport sink (input valid, command, element_index, value_a_re, value_a_im,
		value_b_re, value_b_im, twiddle_re, twiddle_im, output ready);
endinterface

interface fftb_rsp_if import fftb_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [IDX_W-1:0]             out_index;
	logic signed [DATA_WIDTH-1:0] out_re;
	logic signed [DATA_WIDTH-1:0] out_im;
	logic                         last;

	modport source (output valid, out_index, out_re, out_im, last, input ready);
	modport sink (input valid, out_index, out_re, out_im, last, output ready);
endinterface

interface fftb_cfg_if import fftb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] reg_index;
	logic [CFG_DW-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/fftb_ram.sv =====
// ----------------------------------------------------------------------------
// fftb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fftb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fftb_index_calc.sv =====
// ----------------------------------------------------------------------------
// fftb_index_calc
// Twiddle address, output positions and local/partner role for one command.
// ----------------------------------------------------------------------------
module fftb_index_calc import fftb_pkg::*; (
	input  cfg_t             cfg,
	input  logic [IDX_W-1:0] elem,
	output idx_t             idx
);

	logic [LOG_W:0]     span_p1;
	logic [IDX_W-1:0]   mask10;
	logic [IDX_W-1:0]   mj10;
	logic [IDX_W-1:0]   k10;
	logic [IDX_W-1:0]   pos0;
	logic [TABLE_AW-1:0] mask9;
	logic [BASE_W-1:0]  base;
	logic [TABLE_AW-1:0] offset9;
	logic [TABLE_AW-1:0] sel;
	logic [LOG_W-1:0]   rsh;
	logic [RANK_W-1:0]  rank_sh;
	logic [LOG_W-1:0]   sh;
	logic               has_stride;

	always_comb begin
		span_p1 = {1'b0, cfg.span_log2} + (LOG_W+1)'(1);
		// bits below the half-span; shift past the width gives all ones
		mask10  = ~({IDX_W{1'b1}} << cfg.span_log2);
		mj10    = IDX_W'(1) << cfg.span_log2;
		k10     = elem & mask10;
		mask9   = ~({TABLE_AW{1'b1}} << cfg.span_log2);

		idx.is_local = span_p1 <= {1'b0, cfg.part_size_log2};
		pos0         = ((elem & ~mask10) << 1) | k10;
		// partner result keeps the element number as its position
		idx.idx0     = idx.is_local ? pos0 : elem;
		idx.idx1     = pos0 | mj10;

		base    = BASE_W'(cfg.part_rank) << cfg.part_size_log2;
		offset9 = base[TABLE_AW-1:0] & mask9;
		// partner case has span >= part size, so base bit span is a rank bit
		rsh     = cfg.span_log2 - cfg.part_size_log2;
		rank_sh = cfg.part_rank >> rsh;
		idx.take_sum = !rank_sh[0];

		sel = idx.is_local ? k10[TABLE_AW-1:0] : offset9 + elem[TABLE_AW-1:0];

		has_stride = {1'b0, cfg.fft_size_log2} >= span_p1;
		sh         = cfg.fft_size_log2 - cfg.span_log2 - LOG_W'(1);
		idx.tidx   = has_stride ? (sel << sh) : '0;
	end

endmodule

// ===== hw/rtl/fft_radix2_butterfly_stage.sv =====
// ----------------------------------------------------------------------------
// fft_radix2_butterfly_stage
// One radix-2 FFT stage on a partition: twiddle table load, local and
// partner butterflies, Q1.15 twiddles, rounded and saturated results.
// ----------------------------------------------------------------------------
//  channel  dir   beat carries
//  req      in    command, element_index, value_a/b re/im, twiddle re/im
//  rsp      out   out_index, out_re, out_im, last
//  cfg      in    reg_index, wdata (always ready)
//
//  Four register stages: table read, complex multiply, add/sub of the
//  products, round/saturate. Local butterflies emit two beats through rsp
//  and hold the pipeline while the second goes out; loads and partner
//  butterflies sustain one per cycle while rsp does not stall. Each stage
//  stalls only when full and blocked downstream. arst_n clears the stage
//  valids and output phase and resets configuration, not the twiddle table.
// ----------------------------------------------------------------------------
module fft_radix2_butterfly_stage import fftb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	fftb_req_if.sink  req,
	fftb_rsp_if.source rsp,
	fftb_cfg_if.sink  cfg
);

	cfg_t cfg_q;
	idx_t idx_s0;

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic phase_q;
	logic fin;
	logic accept;

	logic [ENTRY_W-1:0] entry_s1;

	logic signed [DATA_WIDTH-1:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic [IDX_W-1:0] idx0_s1, idx1_s1, idx0_s2, idx1_s2, idx0_s3, idx1_s3, idx0_s4, idx1_s4;
	logic loc_s1, loc_s2, loc_s3, loc_s4;
	logic sum_s1, sum_s2, sum_s3, sum_s4;

	logic signed [TWIDDLE_WIDTH:0] wr, wi, wi_raw;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2;
	logic signed [DATA_WIDTH-1:0] a_re_s2, a_im_s2;
	logic signed [T_W-1:0] tr_s3, ti_s3;
	logic signed [SA_W-1:0] sa_re_s3, sa_im_s3;
	logic signed [SUM_W-1:0] s_re, s_im, d_re, d_im;
	logic signed [DATA_WIDTH-1:0] sum_re_s4, sum_im_s4, dif_re_s4, dif_im_s4;
	logic take_sum_out;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fft_size_log2     <= LOG_W'(10);
			cfg_q.span_log2         <= '0;
			cfg_q.part_size_log2    <= LOG_W'(10);
			cfg_q.part_rank         <= '0;
			cfg_q.conjugate_twiddle <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.reg_index))
				CFG_FFT_SIZE_LOG2:  cfg_q.fft_size_log2     <= cfg.wdata[LOG_W-1:0];
				CFG_SPAN_LOG2:      cfg_q.span_log2         <= cfg.wdata[LOG_W-1:0];
				CFG_PART_SIZE_LOG2: cfg_q.part_size_log2    <= cfg.wdata[LOG_W-1:0];
				CFG_PART_RANK:      cfg_q.part_rank         <= cfg.wdata[RANK_W-1:0];
				CFG_CONJ_TWIDDLE:   cfg_q.conjugate_twiddle <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// stall chain
	assign fin   = !loc_s4 || phase_q;
	assign en_s4 = !v_s4 || (rsp.ready && fin);
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req.ready = en_s1;
	assign accept    = req.valid && en_s1;

	fftb_index_calc u_idx (
		.cfg  (cfg_q),
		.elem (req.element_index),
		.idx  (idx_s0)
	);

	fftb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && req.command == CMD_LOAD),
		.waddr (req.element_index[TABLE_AW-1:0]),
		.wdata ({req.twiddle_im, req.twiddle_re}),
		.re    (en_s1),
		.raddr (idx_s0.tidx),
		.rdata (entry_s1)
	);

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= accept && req.command == CMD_BFLY;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (v_s4 && rsp.ready) begin
				phase_q <= !fin;
			end
		end
	end

	// s1: operands beside the table read
	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_re_s1 <= req.value_a_re;
			a_im_s1 <= req.value_a_im;
			b_re_s1 <= req.value_b_re;
			b_im_s1 <= req.value_b_im;
			idx0_s1 <= idx_s0.idx0;
			idx1_s1 <= idx_s0.idx1;
			loc_s1  <= idx_s0.is_local;
			sum_s1  <= idx_s0.take_sum;
		end
	end

	// s2: complex multiply partial products
	always_comb begin
		wr     = (TWIDDLE_WIDTH+1)'($signed(entry_s1[TWIDDLE_WIDTH-1:0]));
		wi_raw = (TWIDDLE_WIDTH+1)'($signed(entry_s1[ENTRY_W-1:TWIDDLE_WIDTH]));
		// 17 bits so that a conjugated -1.0 becomes +1.0
		wi     = cfg_q.conjugate_twiddle ? -wi_raw : wi_raw;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_rr_s2 <= wr * b_re_s1;
			p_ii_s2 <= wi * b_im_s1;
			p_ir_s2 <= wi * b_re_s1;
			p_ri_s2 <= wr * b_im_s1;
			a_re_s2 <= a_re_s1;
			a_im_s2 <= a_im_s1;
			idx0_s2 <= idx0_s1;
			idx1_s2 <= idx1_s1;
			loc_s2  <= loc_s1;
			sum_s2  <= sum_s1;
		end
	end

	// s3: t = w*b, a scaled with the rounding half folded in
	always_ff @(posedge clk) begin
		if (en_s3) begin
			tr_s3    <= T_W'(p_rr_s2) - T_W'(p_ii_s2);
			ti_s3    <= T_W'(p_ir_s2) + T_W'(p_ri_s2);
			sa_re_s3 <= $signed({a_re_s2, 1'b1, {(FRAC_BITS-1){1'b0}}});
			sa_im_s3 <= $signed({a_im_s2, 1'b1, {(FRAC_BITS-1){1'b0}}});
			idx0_s3  <= idx0_s2;
			idx1_s3  <= idx1_s2;
			loc_s3   <= loc_s2;
			sum_s3   <= sum_s2;
		end
	end

	// s4: sum and difference, rounded and saturated
	always_comb begin
		s_re = SUM_W'(sa_re_s3) + SUM_W'(tr_s3);
		s_im = SUM_W'(sa_im_s3) + SUM_W'(ti_s3);
		d_re = SUM_W'(sa_re_s3) - SUM_W'(tr_s3);
		d_im = SUM_W'(sa_im_s3) - SUM_W'(ti_s3);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sum_re_s4 <= round_sat(s_re);
			sum_im_s4 <= round_sat(s_im);
			dif_re_s4 <= round_sat(d_re);
			dif_im_s4 <= round_sat(d_im);
			idx0_s4   <= idx0_s3;
			idx1_s4   <= idx1_s3;
			loc_s4    <= loc_s3;
			sum_s4    <= sum_s3;
		end
	end

	// output beats: local gives sum then difference, partner gives one
	always_comb begin
		take_sum_out  = loc_s4 ? !phase_q : sum_s4;
		rsp.valid     = v_s4;
		rsp.last      = fin;
		rsp.out_index = (loc_s4 && phase_q) ? idx1_s4 : idx0_s4;
		rsp.out_re    = take_sum_out ? sum_re_s4 : dif_re_s4;
		rsp.out_im    = take_sum_out ? sum_im_s4 : dif_im_s4;
	end

endmodule

// ===== hw/rtl/fftb_checker.sv =====
// ----------------------------------------------------------------------------
// fftb_checker
// Port-level checks on the butterfly stage, bound to the top level.
// ----------------------------------------------------------------------------
module fftb_checker import fftb_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_last,
	input logic [IDX_W-1:0]             rsp_out_index,
	input logic signed [DATA_WIDTH-1:0] rsp_out_re,
	input logic signed [DATA_WIDTH-1:0] rsp_out_im
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
			&& $stable(rsp_out_re) && $stable(rsp_out_im) && $stable(rsp_last))
		else $error("fftb: stalled result beat changed");

	// first half of a local pair is followed at once by its second half
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
		else $error("fftb: butterfly pair broken");

	// with nothing waiting at the output the pipeline cannot be blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("fftb: request stalled with empty output");

endmodule

bind fft_radix2_butterfly_stage fftb_checker u_fftb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_last      (rsp.last),
	.rsp_out_index (rsp.out_index),
	.rsp_out_re    (rsp.out_re),
	.rsp_out_im    (rsp.out_im)
);
